>>> hdl/plla_pkg.sv
// plla_pkg: shared types, constants and functions of the poisson log-likelihood accumulator
package plla_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int COUNT_BITS = 16;
	localparam int ACC_W      = 64;
	localparam int LN_W       = 40;
	localparam int PROD_W     = COUNT_BITS + 1 + LN_W;
	localparam int DIV_W      = 33;
	localparam int RND_SH     = 32 - FRAC_BITS;
	localparam int FB_W       = 5;
	localparam int LNF_TOP    = 16;

	localparam logic [31:0] LN2_Q32 = 32'hB172_17F8;
	localparam logic [DIV_W-1:0] ONE_Q32 = DIV_W'(64'h1_0000_0000);
	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	typedef struct packed {
		logic [31:0]           theory;
		logic [15:0]           observed;
		logic                  last;
	} bin_t;

	typedef struct packed {
		logic signed [63:0]    neg2_log_likelihood;
		logic signed [63:0]    const_term;
		logic                  bad_theory;
		logic                  saturated;
	} res_t;

	typedef struct packed {
		logic                  sat;
		logic signed [ACC_W-1:0] sum;
	} sat_res_t;

	// elaboration-time natural log in q32, same steps as the log unit
	function automatic longint ln_q32_f(input longint unsigned x, input int fb);
		int p;
		int i;
		longint unsigned m;
		longint unsigned frac;
		longint unsigned mag;
		longint unsigned prod;
		longint a;
		p = 31;
		frac = 0;
		while (p > 0 && ((x >> p) & 64'd1) == 64'd0)
			p = p - 1;
		m = x << (31 - p);
		for (i = 0; i < 32; i++) begin
			m = (m * m) >> 31;
			frac = frac << 1;
			if (m >= 64'h1_0000_0000) begin
				m = m >> 1;
				frac = frac | 64'd1;
			end
		end
		a = longint'(p - fb) * 64'sh1_0000_0000 + longint'(frac);
		mag = (a < 0) ? longint'(-a) : a;
		prod = (mag >> 32) * 64'(LN2_Q32) + (((mag & 64'hFFFF_FFFF) * 64'(LN2_Q32)) >> 32);
		return (a < 0) ? -longint'(prod) : longint'(prod);
	endfunction

	function automatic longint lnf_f(input int n);
		longint s;
		int k;
		s = 0;
		for (k = 2; k <= n; k++)
			s = s + ln_q32_f(longint'(k), 0);
		return s;
	endfunction

	localparam longint LNF_TAB [0:LNF_TOP] = '{
		lnf_f(0), lnf_f(1), lnf_f(2), lnf_f(3), lnf_f(4), lnf_f(5), lnf_f(6),
		lnf_f(7), lnf_f(8), lnf_f(9), lnf_f(10), lnf_f(11), lnf_f(12),
		lnf_f(13), lnf_f(14), lnf_f(15), lnf_f(16)
	};

	localparam longint LN16 = ln_q32_f(64'd16, 0);
	localparam longint ST16 = LN16 * 16 - 16 * 64'sh1_0000_0000 + LN16 / 2
		+ 64'sh1_0000_0000 / 192 - (64'sh1_0000_0000 / 5760) / 256;
	localparam logic signed [ACC_W-1:0] LNF_OFS = LNF_TAB[LNF_TOP] - ST16;

	// q32 to FRAC_BITS fraction bits, half up
	function automatic logic signed [ACC_W-1:0] rnd_q32(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] t;
		t = v + ACC_W'(64'd1 << (RND_SH - 1));
		return t >>> RND_SH;
	endfunction

	function automatic sat_res_t sat_add(input logic signed [ACC_W-1:0] a,
			input logic signed [ACC_W-1:0] b);
		sat_res_t r;
		logic signed [ACC_W-1:0] s;
		s = a + b;
		r.sat = (a[ACC_W-1] == b[ACC_W-1]) && (s[ACC_W-1] != a[ACC_W-1]);
		r.sum = r.sat ? (b[ACC_W-1] ? ACC_MIN : ACC_MAX) : s;
		return r;
	endfunction

endpackage

>>> hdl/plla_ram.sv
// plla_ram: generic single-write, single-read ram with registered read data
module plla_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 2
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);
	logic [WIDTH-1:0] mem [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

>>> hdl/plla_ln.sv
// plla_ln: iterative natural logarithm unit, one squaring step per cycle
module plla_ln (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic [31:0]                           x,
	input  logic [plla_pkg::FB_W-1:0]             fb,
	output logic                                  done,
	output logic signed [plla_pkg::LN_W-1:0]      result
);
	import plla_pkg::*;

	typedef enum logic [4:0] {
		L_IDLE = 5'b00001,
		L_NORM = 5'b00010,
		L_SQR  = 5'b00100,
		L_FIN1 = 5'b01000,
		L_FIN2 = 5'b10000
	} ln_state_t;

	ln_state_t          state_q;
	logic [31:0]        x_q;
	logic [FB_W-1:0]    fb_q;
	logic [4:0]         p_q;
	logic [32:0]        m_q;
	logic [31:0]        frac_q;
	logic [4:0]         cnt_q;
	logic               neg_q;
	logic [38:0]        mag_q;
	logic               done_q;
	logic signed [LN_W-1:0] result_q;

	logic [4:0]         p_c;
	logic [63:0]        sq_c;
	logic [32:0]        mn_c;
	logic signed [38:0] a_c;
	logic signed [6:0]  ip_c;
	logic [LN_W-1:0]    prod_c;

	always_comb begin
		p_c = '0;
		for (int i = 1; i < 32; i++)
			if (x_q[i])
				p_c = 5'(i);
		sq_c = 64'(m_q[31:0]) * 64'(m_q[31:0]);
		mn_c = sq_c[63:31];
		ip_c = $signed({2'b00, p_q}) - $signed(7'(fb_q));
		a_c = {ip_c, frac_q};
		prod_c = LN_W'(64'(mag_q[38:32]) * 64'(LN2_Q32))
			+ LN_W'((64'(mag_q[31:0]) * 64'(LN2_Q32)) >> 32);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				L_IDLE: begin
					if (start)
						state_q <= L_NORM;
				end
				L_NORM: state_q <= L_SQR;
				L_SQR: begin
					if (cnt_q == 5'd31)
						state_q <= L_FIN1;
				end
				L_FIN1: state_q <= L_FIN2;
				L_FIN2: begin
					done_q  <= 1'b1;
					state_q <= L_IDLE;
				end
				default: state_q <= L_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			L_IDLE: begin
				if (start) begin
					x_q  <= x;
					fb_q <= fb;
				end
			end
			L_NORM: begin
				p_q    <= p_c;
				m_q    <= {1'b0, x_q << (5'd31 - p_c)};
				frac_q <= '0;
				cnt_q  <= '0;
			end
			L_SQR: begin
				m_q    <= mn_c[32] ? {1'b0, mn_c[32:1]} : mn_c;
				frac_q <= {frac_q[30:0], mn_c[32]};
				cnt_q  <= cnt_q + 5'd1;
			end
			L_FIN1: begin
				neg_q <= a_c[38];
				mag_q <= a_c[38] ? 39'(-a_c) : 39'(a_c);
			end
			L_FIN2: begin
				result_q <= neg_q ? -$signed(prod_c) : $signed(prod_c);
			end
			default: ;
		endcase
	end

	assign done   = done_q;
	assign result = result_q;
endmodule

>>> hdl/plla_div.sv
// plla_div: restoring divider, one quotient bit per cycle
module plla_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [plla_pkg::DIV_W-1:0]     num,
	input  logic [plla_pkg::DIV_W-1:0]     den,
	output logic                           done,
	output logic [plla_pkg::DIV_W-1:0]     quot
);
	import plla_pkg::*;

	logic               busy_q;
	logic               done_q;
	logic [5:0]         cnt_q;
	logic [DIV_W-1:0]   num_q;
	logic [DIV_W-1:0]   den_q;
	logic [DIV_W:0]     rem_q;
	logic [DIV_W-1:0]   quot_q;

	logic [DIV_W:0]     rsh_c;
	logic               ge_c;

	assign rsh_c = {rem_q[DIV_W-1:0], num_q[DIV_W-1]};
	assign ge_c  = rsh_c >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == 6'(DIV_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q  <= num;
			den_q  <= den;
			rem_q  <= '0;
			quot_q <= '0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			num_q  <= {num_q[DIV_W-2:0], 1'b0};
			rem_q  <= ge_c ? rsh_c - {1'b0, den_q} : rsh_c;
			quot_q <= {quot_q[DIV_W-2:0], ge_c};
			cnt_q  <= cnt_q + 6'd1;
		end
	end

	assign done = done_q;
	assign quot = quot_q;
endmodule

>>> hdl/poisson_log_likelihood_accumulator.sv
// poisson_log_likelihood_accumulator: top level, sequencer around the sum ram
// Usage:
//  bins come in on bin/bin_valid, the block holds bin_stall high while it
//  works on a bin. One result leaves on res/res_valid per bin marked last.
//  approx_mode is to be written through cfg_we/cfg_wdata only while the block
//  is idle; the user is bound to this, the block itself does not enforce it.
// One bin is worked on at a time. A zero theory skips the main term, any
//  other theory takes the log unit for it. The count term uses a table for
//  counts 2 to 16 in exact mode, the log unit in approximate mode, and the
//  log unit plus three divisions for larger counts in exact mode. A last bin
//  then reads both sums and forms the result.
// Both sums live in a two-entry ram; valid bits make unwritten entries read
//  as zero, so reset and the clear after a last bin take no sweep.
// Reset clears the sequencer, flags, valid bits and the result valid flag.
// A held result waits in the output register while res_stall is high; a next
//  result that is ready before then waits in the sequencer.
module poisson_log_likelihood_accumulator (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               bin_valid,
	output logic               bin_stall,
	input  plla_pkg::bin_t     bin,
	output logic               res_valid,
	input  logic               res_stall,
	output plla_pkg::res_t     res,
	input  logic               cfg_we,
	input  logic               cfg_wdata
);
	import plla_pkg::*;

	typedef enum logic [25:0] {
		S_IDLE = 26'd1 << 0,
		S_LNT  = 26'd1 << 1,
		S_MT1  = 26'd1 << 2,
		S_MT2  = 26'd1 << 3,
		S_MT3  = 26'd1 << 4,
		S_CT0  = 26'd1 << 5,
		S_LNO  = 26'd1 << 6,
		S_CA1  = 26'd1 << 7,
		S_CA2  = 26'd1 << 8,
		S_SD1  = 26'd1 << 9,
		S_SD1W = 26'd1 << 10,
		S_SD2W = 26'd1 << 11,
		S_SD3W = 26'd1 << 12,
		S_ST1  = 26'd1 << 13,
		S_ST2  = 26'd1 << 14,
		S_ST3  = 26'd1 << 15,
		S_ST4  = 26'd1 << 16,
		S_ST5  = 26'd1 << 17,
		S_CRND = 26'd1 << 18,
		S_RD0  = 26'd1 << 19,
		S_WB0  = 26'd1 << 20,
		S_WB1  = 26'd1 << 21,
		S_FR1  = 26'd1 << 22,
		S_FR2  = 26'd1 << 23,
		S_F1   = 26'd1 << 24,
		S_F2   = 26'd1 << 25
	} seq_state_t;

	localparam logic ADDR_MAIN  = 1'b0;
	localparam logic ADDR_CONST = 1'b1;

	seq_state_t                 state_q;
	logic                       approx_q;
	logic [31:0]                theory_q;
	logic [COUNT_BITS-1:0]      obs_q;
	logic                       last_q;
	logic                       zero_seen_q;
	logic                       ovf_seen_q;
	logic [1:0]                 valid_q;
	logic signed [LN_W-1:0]     lnv_q;
	logic signed [PROD_W-1:0]   prod_q;
	logic signed [ACC_W-1:0]    v_q;
	logic signed [ACC_W-1:0]    mterm_q;
	logic signed [ACC_W-1:0]    cterm_q;
	logic [31:0]                nn_q;
	logic [DIV_W-1:0]           q1_q;
	logic [DIV_W-1:0]           q3_q;
	logic signed [ACC_W-1:0]    main_fin_q;
	logic signed [ACC_W-1:0]    const_fin_q;
	logic signed [ACC_W-1:0]    tot_q;
	logic                       sat_fin_q;
	logic                       rd_addr_s1;
	logic                       res_valid_q;
	res_t                       res_q;

	logic                       ln_start;
	logic [31:0]                ln_x;
	logic [FB_W-1:0]            ln_fb;
	logic                       ln_done;
	logic signed [LN_W-1:0]     ln_res;
	logic                       div_start;
	logic [DIV_W-1:0]           div_num;
	logic [DIV_W-1:0]           div_den;
	logic                       div_done;
	logic [DIV_W-1:0]           div_quot;
	logic                       ram_we;
	logic                       ram_waddr;
	logic signed [ACC_W-1:0]    ram_wdata;
	logic                       ram_raddr;
	logic [ACC_W-1:0]           ram_rdata;

	logic                       accept;
	logic                       need_ln;
	logic                       small_exact;
	logic signed [PROD_W-1:0]   mul_c;
	logic signed [ACC_W-1:0]    eff_c;
	sat_res_t                   acc_c;
	sat_res_t                   tot_c;
	sat_res_t                   dbl_c;
	logic                       res_free;

	assign accept      = (state_q == S_IDLE) && bin_valid;
	assign bin_stall   = (state_q != S_IDLE);
	assign need_ln     = (obs_q >= COUNT_BITS'(2)) && (approx_q || obs_q > COUNT_BITS'(LNF_TOP));
	assign small_exact = (obs_q >= COUNT_BITS'(2)) && !approx_q
		&& (obs_q <= COUNT_BITS'(LNF_TOP));
	assign mul_c       = $signed({1'b0, obs_q}) * lnv_q;
	assign eff_c       = valid_q[rd_addr_s1] ? $signed(ram_rdata) : '0;
	assign acc_c       = sat_add(eff_c, (state_q == S_WB0) ? mterm_q : cterm_q);
	assign tot_c       = sat_add(main_fin_q, const_fin_q);
	assign dbl_c       = sat_add(tot_q, tot_q);
	assign res_free    = !res_valid_q || !res_stall;

	always_comb begin
		ln_start = 1'b0;
		ln_x     = 32'(obs_q);
		ln_fb    = '0;
		if (state_q == S_IDLE) begin
			ln_start = bin_valid && (bin.theory != 32'd0);
			ln_x     = bin.theory;
			ln_fb    = FB_W'(FRAC_BITS);
		end else if (state_q == S_CT0) begin
			ln_start = need_ln;
		end
	end

	always_comb begin
		div_start = 1'b0;
		div_num   = ONE_Q32;
		div_den   = DIV_W'(obs_q) * DIV_W'(12);
		case (state_q)
			S_SD1: div_start = 1'b1;
			S_SD1W: begin
				div_start = div_done;
				div_den   = DIV_W'(obs_q) * DIV_W'(360);
			end
			S_SD2W: begin
				div_start = div_done;
				div_num   = div_quot;
				div_den   = DIV_W'(nn_q);
			end
			default: ;
		endcase
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = ADDR_MAIN;
		ram_wdata = acc_c.sum;
		ram_raddr = ADDR_MAIN;
		case (state_q)
			S_WB0: begin
				ram_we    = 1'b1;
				ram_raddr = ADDR_CONST;
			end
			S_WB1: begin
				ram_we    = 1'b1;
				ram_waddr = ADDR_CONST;
			end
			S_FR1: ram_raddr = ADDR_CONST;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			approx_q    <= 1'b0;
			zero_seen_q <= 1'b0;
			ovf_seen_q  <= 1'b0;
			valid_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_we)
				approx_q <= cfg_wdata;
			if (state_q == S_F2 && res_free)
				res_valid_q <= 1'b1;
			else if (res_valid_q && !res_stall)
				res_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (bin.theory == 32'd0) begin
							zero_seen_q <= 1'b1;
							state_q     <= S_CT0;
						end else begin
							state_q <= S_LNT;
						end
					end
				end
				S_LNT: if (ln_done) state_q <= S_MT1;
				S_MT1: state_q <= S_MT2;
				S_MT2: state_q <= S_MT3;
				S_MT3: state_q <= S_CT0;
				S_CT0: begin
					if (need_ln)
						state_q <= S_LNO;
					else if (small_exact)
						state_q <= S_CRND;
					else
						state_q <= S_RD0;
				end
				S_LNO: if (ln_done) state_q <= approx_q ? S_CA1 : S_SD1;
				S_CA1: state_q <= S_CA2;
				S_CA2: state_q <= S_CRND;
				S_SD1: state_q <= S_SD1W;
				S_SD1W: if (div_done) state_q <= S_SD2W;
				S_SD2W: if (div_done) state_q <= S_SD3W;
				S_SD3W: if (div_done) state_q <= S_ST1;
				S_ST1: state_q <= S_ST2;
				S_ST2: state_q <= S_ST3;
				S_ST3: state_q <= S_ST4;
				S_ST4: state_q <= S_ST5;
				S_ST5: state_q <= S_CRND;
				S_CRND: state_q <= S_RD0;
				S_RD0: state_q <= S_WB0;
				S_WB0: begin
					valid_q[ADDR_MAIN] <= 1'b1;
					if (acc_c.sat)
						ovf_seen_q <= 1'b1;
					state_q <= S_WB1;
				end
				S_WB1: begin
					valid_q[ADDR_CONST] <= 1'b1;
					if (acc_c.sat)
						ovf_seen_q <= 1'b1;
					state_q <= last_q ? S_FR1 : S_IDLE;
				end
				S_FR1: state_q <= S_FR2;
				S_FR2: state_q <= S_F1;
				S_F1: state_q <= S_F2;
				S_F2: begin
					if (res_free) begin
						valid_q     <= '0;
						zero_seen_q <= 1'b0;
						ovf_seen_q  <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_addr_s1 <= ram_raddr;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					theory_q <= bin.theory;
					obs_q    <= bin.observed[COUNT_BITS-1:0];
					last_q   <= bin.last;
					mterm_q  <= '0;
				end
			end
			S_LNT: if (ln_done) lnv_q <= ln_res;
			S_MT1: prod_q <= mul_c;
			S_MT2: v_q <= ACC_W'({theory_q, {RND_SH{1'b0}}}) - ACC_W'(prod_q);
			S_MT3: mterm_q <= rnd_q32(v_q);
			S_CT0: begin
				cterm_q <= '0;
				v_q     <= LNF_TAB[obs_q[4:0]];
			end
			S_LNO: if (ln_done) lnv_q <= ln_res;
			S_CA1: prod_q <= mul_c;
			S_CA2: v_q <= ACC_W'(prod_q);
			S_SD1: begin
				prod_q <= mul_c;
				nn_q   <= 32'(obs_q) * 32'(obs_q);
			end
			S_SD1W: if (div_done) q1_q <= div_quot;
			S_SD3W: if (div_done) q3_q <= div_quot;
			S_ST1: v_q <= ACC_W'(prod_q) - ACC_W'({obs_q, 32'd0});
			S_ST2: v_q <= v_q + ACC_W'(lnv_q >>> 1);
			S_ST3: v_q <= v_q + ACC_W'(q1_q);
			S_ST4: v_q <= v_q - ACC_W'(q3_q);
			S_ST5: v_q <= v_q + LNF_OFS;
			S_CRND: cterm_q <= rnd_q32(v_q);
			S_FR1: main_fin_q <= eff_c;
			S_FR2: const_fin_q <= eff_c;
			S_F1: begin
				tot_q     <= tot_c.sum;
				sat_fin_q <= ovf_seen_q | tot_c.sat;
			end
			S_F2: begin
				if (res_free) begin
					res_q.neg2_log_likelihood <= dbl_c.sum;
					res_q.const_term          <= const_fin_q;
					res_q.bad_theory          <= zero_seen_q;
					res_q.saturated           <= sat_fin_q | dbl_c.sat;
				end
			end
			default: ;
		endcase
	end

	plla_ln u_ln (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ln_start),
		.x      (ln_x),
		.fb     (ln_fb),
		.done   (ln_done),
		.result (ln_res)
	);

	plla_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	plla_ram #(
		.WIDTH (ACC_W),
		.DEPTH (2)
	) u_sum_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign res_valid = res_valid_q;
	assign res       = res_q;
endmodule
